>>> rtl/ifig_pkg.sv
`default_nettype none

package ifig_pkg;

  localparam int LEN_WIDTH  = 32;
  localparam int CODE_W     = 8;
  localparam int AFTER_W    = 40;
  localparam int SHORT_W    = 32;
  localparam int RATE_W     = 40;
  localparam int DELAY_W    = 33;
  localparam int TOTAL_W    = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 41;

  // pacing scale, one bit of it per multiplier step
  localparam int NS_W = 30;
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [DELAY_W-1:0] DELAY_CAP = 33'd5000000000;

  localparam int PROD_W    = LEN_WIDTH + NS_W;
  localparam int QUO_W     = DELAY_W + 1;
  localparam int MUL_CNT_W = $clog2(NS_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int CMP_W     = (LEN_WIDTH > SHORT_W) ? LEN_WIDTH : SHORT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_ERROR_CODE   = 4'd0,
    REG_READ_ERROR_AFTER  = 4'd1,
    REG_READ_SHORT_LIMIT  = 4'd2,
    REG_READ_RATE         = 4'd3,
    REG_WRITE_ERROR_CODE  = 4'd4,
    REG_WRITE_ERROR_AFTER = 4'd5,
    REG_WRITE_SHORT_LIMIT = 4'd6,
    REG_WRITE_RATE        = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                 func;
    logic [LEN_WIDTH-1:0] request_len;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0]    error_code;
    logic [LEN_WIDTH-1:0] granted_len;
    logic [DELAY_W-1:0]   delay_ns;
  } rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               after_neg;
    logic [AFTER_W-1:0] after_val;
    logic               short_neg;
    logic [SHORT_W-1:0] short_val;
    logic [RATE_W-1:0]  rate;
  } rule_t;

endpackage

`default_nettype wire

>>> rtl/ifig_cfg.sv
`default_nettype none

module ifig_cfg
  import ifig_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output rule_t                      rd_rule,
  output rule_t                      wr_rule
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_rule.code      <= '0;
      rd_rule.after_neg <= 1'b1;
      rd_rule.after_val <= '0;
      rd_rule.short_neg <= 1'b1;
      rd_rule.short_val <= '0;
      rd_rule.rate      <= '0;
      wr_rule.code      <= '0;
      wr_rule.after_neg <= 1'b1;
      wr_rule.after_val <= '0;
      wr_rule.short_neg <= 1'b1;
      wr_rule.short_val <= '0;
      wr_rule.rate      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_READ_ERROR_CODE: begin
          rd_rule.code <= cfg_data[CODE_W-1:0];
        end
        REG_READ_ERROR_AFTER: begin
          rd_rule.after_neg <= cfg_data[AFTER_W];
          rd_rule.after_val <= cfg_data[AFTER_W-1:0];
        end
        REG_READ_SHORT_LIMIT: begin
          rd_rule.short_neg <= cfg_data[SHORT_W];
          rd_rule.short_val <= cfg_data[SHORT_W-1:0];
        end
        REG_READ_RATE: begin
          rd_rule.rate <= cfg_data[RATE_W-1:0];
        end
        REG_WRITE_ERROR_CODE: begin
          wr_rule.code <= cfg_data[CODE_W-1:0];
        end
        REG_WRITE_ERROR_AFTER: begin
          wr_rule.after_neg <= cfg_data[AFTER_W];
          wr_rule.after_val <= cfg_data[AFTER_W-1:0];
        end
        REG_WRITE_SHORT_LIMIT: begin
          wr_rule.short_neg <= cfg_data[SHORT_W];
          wr_rule.short_val <= cfg_data[SHORT_W-1:0];
        end
        REG_WRITE_RATE: begin
          wr_rule.rate <= cfg_data[RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ifig_smul.sv
`default_nettype none

module ifig_smul
  import ifig_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [LEN_WIDTH-1:0] len,
  output logic                      done,
  output logic [PROD_W-1:0]         prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [LEN_WIDTH-1:0] mcand;
  logic [LEN_WIDTH-1:0] acc;
  logic [NS_W-1:0]      low;
  logic [LEN_WIDTH:0]   sum;

  // one scale bit per cycle, lsb first; product bits leave acc at the bottom
  assign sum  = {1'b0, acc} + (NS_PER_SEC[cnt] ? {1'b0, mcand} : '0);
  assign prod = {acc, low};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(NS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= len;
      acc   <= '0;
    end else if (busy) begin
      acc <= sum[LEN_WIDTH:1];
      low <= {sum[0], low[NS_W-1:1]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/ifig_sdiv.sv
`default_nettype none

module ifig_sdiv
  import ifig_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [RATE_W-1:0] divisor,
  output logic                   done,
  output logic [DELAY_W-1:0]     quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dvd;
  logic [RATE_W-1:0]    dvs;
  logic [RATE_W-1:0]    rem;
  logic [QUO_W-1:0]     q;
  logic                 over;
  logic [RATE_W:0]      rem_sh;
  logic                 ge;
  logic [RATE_W:0]      diff;

  // restoring division, one quotient bit per cycle, msb first
  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};
  assign quo    = (over || (q > {1'b0, DELAY_CAP})) ? DELAY_CAP : q[DELAY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
    end else if (busy) begin
      dvd  <= {dvd[PROD_W-2:0], 1'b0};
      rem  <= ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      q    <= {q[QUO_W-2:0], ge};
      over <= over | q[QUO_W-1];
    end
  end

endmodule

`default_nettype wire

>>> rtl/io_fault_injection_gate_core.sv
// io fault injection gate
// req channel (req_valid/req_ready, req): one word per i/o request, a
// direction and a requested length. rsp channel (rsp_valid/rsp_ready, rsp):
// one word per request with the injected error code, the clamped length
// and the pacing delay in ns. cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes the eight rule registers, always ready; write only idle.
// a request with a nonzero rate and length runs a bit-serial multiply by
// 1e9 and then a restoring divide by the rate, one bit per cycle over
// LEN_WIDTH + 30 dividend bits, before its response word is loaded. with
// a zero rate or length it goes straight to loading the response. one
// request is in flight at a time; req_ready returns the cycle after the
// response word is loaded.
// reset clears the rules to their defaults, both byte totals and the
// response valid flag. a stalled receiver holds the response word; the block
// still takes the next request and stops before loading its response.
`default_nettype none

module io_fault_injection_gate_core
  import ifig_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire req_t                  req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output rsp_t                       rsp,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t               state;
  state_t               state_next;
  rule_t                rd_rule;
  rule_t                wr_rule;
  rule_t                rule_in;
  rule_t                rule_q;
  logic                 func_q;
  logic [LEN_WIDTH-1:0] len_q;
  logic                 zero_delay;
  logic [TOTAL_W-1:0]   rd_total;
  logic [TOTAL_W-1:0]   wr_total;
  logic [TOTAL_W-1:0]   total_sel;
  logic                 accept;
  logic                 skip;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_prod;
  logic                 div_done;
  logic [DELAY_W-1:0]   div_quo;
  logic                 load_rsp;
  logic                 clamp;
  logic [LEN_WIDTH-1:0] granted;
  logic                 fire;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   total_next;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign rule_in   = req.func ? wr_rule : rd_rule;
  assign skip      = (rule_in.rate == '0) || (req.request_len == '0);
  assign rule_q    = func_q ? wr_rule : rd_rule;
  assign total_sel = func_q ? wr_total : rd_total;

  ifig_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_rule   (rd_rule),
    .wr_rule   (wr_rule)
  );

  ifig_smul u_smul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .len   (req.request_len),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ifig_sdiv u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (mul_prod),
    .divisor  (rule_q.rate),
    .done     (div_done),
    .quo      (div_quo)
  );

  // short clamp, error decision and saturating total
  assign clamp   = !rule_q.short_neg &&
                   (CMP_W'(rule_q.short_val) < CMP_W'(len_q));
  assign granted = clamp ? LEN_WIDTH'(rule_q.short_val) : len_q;
  assign fire    = (rule_q.code != '0) &&
                   (rule_q.after_neg || (total_sel >= TOTAL_W'(rule_q.after_val)));
  assign sum        = {1'b0, total_sel} + (TOTAL_W + 1)'(granted);
  assign total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    mul_start  = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (skip) begin
            state_next = ST_FIN;
          end else begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= req.func;
      len_q      <= req.request_len;
      zero_delay <= skip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_total  <= '0;
      wr_total  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
        if (!fire) begin
          if (func_q) begin
            wr_total <= total_next;
          end else begin
            rd_total <= total_next;
          end
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.error_code  <= fire ? rule_q.code : '0;
      rsp.granted_len <= granted;
      rsp.delay_ns    <= zero_delay ? '0 : div_quo;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ifig_chk.sv
`default_nettype none

module ifig_chk
  import ifig_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // a stalled response word stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // delay never exceeds the five second cap
  a_delay_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.delay_ns <= DELAY_CAP)
    else $error("delay above cap");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a new response word is loaded only while no request is being taken
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response appeared from idle");

endmodule

bind io_fault_injection_gate_core ifig_chk u_ifig_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
